/* rtl/core/dfcc_pkg.sv */
`default_nettype none

package dfcc_pkg;

  // supervisory states
  localparam logic [2:0] ST_SETUP    = 3'd0;
  localparam logic [2:0] ST_WAITING  = 3'd1;
  localparam logic [2:0] ST_STABLE   = 3'd2;
  localparam logic [2:0] ST_WARNING  = 3'd3;
  localparam logic [2:0] ST_CRITICAL = 3'd4;

  // motor actions
  localparam logic [1:0] MA_NONE    = 2'd0;
  localparam logic [1:0] MA_DISABLE = 2'd1;
  localparam logic [1:0] MA_OPEN    = 2'd2;
  localparam logic [1:0] MA_CLOSE   = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_CLOSED = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_TOL     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_PERIOD  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_STEPS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TMO    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DROPS_PER_ML = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIMIT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_WIN    = 4'd7;

  // flow divider: flow = 36e9 / (interval_us * drops_per_ml), 0.1 ml/h
  localparam int unsigned NUM_W  = 36;
  localparam int unsigned DEN_W  = 38;
  localparam int unsigned Q_W    = 12;
  localparam int unsigned DSH_W  = DEN_W + Q_W - 1;
  localparam logic [NUM_W-1:0] FLOW_NUM = 36'd36000000000;
  // denominators below this give a flow above 350.0 ml/h
  localparam logic [DEN_W-1:0] MIN_DEN  = 38'd10285715;

  localparam logic [6:0]  BATTERY_LOW = 7'd20;
  localparam logic [16:0] VOLUME_LOW  = 17'd500;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/core/dfcc_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees
// the quotient fits in Q_W bits.
module dfcc_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [dfcc_pkg::DEN_W-1:0]   den_i,
  output dfcc_pkg::div_stat_t               stat_o,
  output logic      [dfcc_pkg::Q_W-1:0]     quot_o
);

  localparam int unsigned CNT_W = $clog2(dfcc_pkg::Q_W);

  logic [dfcc_pkg::NUM_W-1:0] rem_q, rem_d;
  logic [dfcc_pkg::DSH_W-1:0] dsh_q;
  logic [dfcc_pkg::DSH_W-1:0] rem_ext, diff;
  logic [dfcc_pkg::Q_W-1:0]   quot_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q, done_q;
  logic                       fits;

  assign rem_ext = dfcc_pkg::DSH_W'(rem_q);
  assign diff    = rem_ext - dsh_q;
  assign fits    = rem_ext >= dsh_q;
  assign rem_d   = fits ? diff[dfcc_pkg::NUM_W-1:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(dfcc_pkg::Q_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dfcc_pkg::FLOW_NUM;
      dsh_q  <= dfcc_pkg::DSH_W'(den_i) << (dfcc_pkg::Q_W - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[dfcc_pkg::Q_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire

/* rtl/core/drip_flow_clamp_controller.sv */
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i / in_stall_o   tick readings (12 fields)
// out       source     out_valid_o / out_stall_i next state, flow, motor command
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A tick passes SEQ_MUL, SEQ_CHK and SEQ_FIN, and SEQ_DIV before SEQ_FIN when
// the divider runs (12 quotient bits, one per cycle through its one subtractor).
// The next tick is accepted once the result sits in the output register,
// even while out_stall_i holds it there; a stalled result delays the
// following tick's final cycle. Reset clears timers, snapshot, sticky flags
// and loads the register defaults; cfg writes are always taken.
`default_nettype none

module drip_flow_clamp_controller #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tick input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        is_running_i,
  input  wire logic [2:0]  current_state_i,
  input  wire logic [13:0] target_flow_i,
  input  wire logic [15:0] clamp_position_i,
  input  wire logic        forced_blockage_i,
  input  wire logic [16:0] volume_left_i,
  input  wire logic [6:0]  battery_percent_i,
  input  wire logic [31:0] edge_count_i,
  input  wire logic [31:0] drop_interval_us_i,
  input  wire logic [31:0] last_drop_ms_i,
  input  wire logic        enough_drops_i,
  // result
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       next_state_o,
  output logic             still_running_o,
  output logic [11:0]      flow_measured_o,
  output logic [1:0]       motor_action_o,
  output logic [15:0]      motor_steps_o,
  output logic             noisy_flag_o,
  output logic             drops_seen_flag_o,
  // configuration
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dfcc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [dfcc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned CW = (TIME_BITS > 20) ? TIME_BITS : 20;

  localparam logic [2:0] SEQ_IDLE = 3'd0;
  localparam logic [2:0] SEQ_MUL  = 3'd1;
  localparam logic [2:0] SEQ_CHK  = 3'd2;
  localparam logic [2:0] SEQ_DIV  = 3'd3;
  localparam logic [2:0] SEQ_FIN  = 3'd4;

  // configuration registers
  logic [15:0] clamp_closed_q;
  logic [9:0]  flow_tol_q;
  logic [15:0] ctrl_period_q;
  logic [9:0]  corr_steps_q;
  logic [19:0] block_tmo_q;
  logic [5:0]  drops_per_ml_q;
  logic [7:0]  noise_limit_q;
  logic [15:0] noise_win_q;

  // persistent state
  logic [TW-1:0] last_corr_q, last_noise_q;
  logic [31:0]   edge_snap_q;
  logic          noisy_q, seen_q;

  // latched tick
  logic [31:0] now_q, edges_q, interval_q, last_drop_q;
  logic        run_q, forced_q, enough_q;
  logic [2:0]  st_q;
  logic [13:0] target_q;
  logic [15:0] pos_q;
  logic [16:0] vol_q;
  logic [6:0]  batt_q;

  // sequencer and intermediate results
  logic [2:0]                  seq_q;
  logic [dfcc_pkg::DEN_W-1:0]  den_q;
  logic                        since_gt_q, noise_due_q, noise_hit_q, corr_due_q;
  logic                        flow_go_q, flow_noisy_q;

  // output register
  logic        out_valid_q;
  logic [2:0]  o_state_q;
  logic        o_run_q;
  logic [11:0] o_flow_q;
  logic [1:0]  o_act_q;
  logic [15:0] o_steps_q;
  logic        o_noisy_q, o_seen_q;

  dfcc_pkg::div_stat_t        div_stat;
  logic [dfcc_pkg::Q_W-1:0]   div_quot;
  logic                       div_start;

  logic          in_beat, out_free, fin_fire;
  logic [TW-1:0] now_t, since_t;
  logic          window_ok, den_small;

  assign in_stall_o  = (seq_q != SEQ_IDLE);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign fin_fire    = (seq_q == SEQ_FIN) && out_free;

  assign now_t     = TW'(now_q);
  assign since_t   = now_t - TW'(last_drop_q);
  assign window_ok = (interval_q != '0) && !since_gt_q;
  assign den_small = den_q < dfcc_pkg::MIN_DEN;
  assign div_start = (seq_q == SEQ_CHK) && window_ok && !den_small;

  dfcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .den_i  (den_q),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  // ---------------- final-cycle decision ----------------
  logic               idle_path, crit_path, blocked;
  logic               noisy_n, seen_n, warn, err_hi, err_lo;
  logic [11:0]        flow_v, measured;
  logic signed [15:0] err_s, tol_s;
  logic [2:0]         st_run;
  logic [2:0]         r_state;
  logic               r_run;
  logic [11:0]        r_flow;
  logic [1:0]         r_act;
  logic [15:0]        r_steps;
  logic               upd_state, upd_corr;

  always_comb begin
    idle_path = !run_q && (st_q != dfcc_pkg::ST_CRITICAL);
    crit_path = (st_q == dfcc_pkg::ST_CRITICAL);
    flow_v    = flow_go_q ? div_quot : '0;
    noisy_n   = noisy_q || (noise_due_q && noise_hit_q) || flow_noisy_q;
    seen_n    = seen_q || enough_q;
    measured  = (!forced_q && !noisy_n && seen_n) ? flow_v : '0;
    blocked   = seen_n && !forced_q && since_gt_q;
    err_s     = signed'({2'b00, target_q}) - signed'({4'b0000, measured});
    tol_s     = signed'({6'b000000, flow_tol_q});
    err_hi    = err_s > tol_s;
    err_lo    = err_s < -tol_s;
    warn      = (seen_n && (err_hi || err_lo)) || (batt_q < dfcc_pkg::BATTERY_LOW) ||
                (vol_q < dfcc_pkg::VOLUME_LOW);
    st_run    = st_q;
    if (st_q == dfcc_pkg::ST_STABLE && warn) begin
      st_run = dfcc_pkg::ST_WARNING;
    end else if (st_q == dfcc_pkg::ST_WARNING && !warn) begin
      st_run = dfcc_pkg::ST_STABLE;
    end

    upd_state = 1'b0;
    upd_corr  = 1'b0;
    r_state   = st_q;
    r_run     = run_q;
    r_flow    = '0;
    r_act     = dfcc_pkg::MA_NONE;
    r_steps   = '0;

    priority if (idle_path) begin
      r_run = 1'b0;
      r_act = dfcc_pkg::MA_DISABLE;
    end else if (crit_path) begin
      if (pos_q < clamp_closed_q) begin
        r_act   = dfcc_pkg::MA_CLOSE;
        r_steps = clamp_closed_q - pos_q;
      end else begin
        r_state = dfcc_pkg::ST_WAITING;
        r_run   = 1'b0;
        r_act   = dfcc_pkg::MA_DISABLE;
      end
    end else if (blocked) begin
      upd_state = 1'b1;
      r_state   = dfcc_pkg::ST_CRITICAL;
      r_flow    = measured;
    end else begin
      upd_state = 1'b1;
      upd_corr  = corr_due_q;
      r_state   = st_run;
      r_flow    = measured;
      if (corr_due_q && seen_n && (target_q != '0) && !forced_q) begin
        if (err_hi) begin
          r_act   = dfcc_pkg::MA_OPEN;
          r_steps = {6'b000000, corr_steps_q};
        end else if (err_lo) begin
          r_act   = dfcc_pkg::MA_CLOSE;
          r_steps = {6'b000000, corr_steps_q};
        end
      end
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_IDLE;
    end else begin
      unique case (seq_q)
        SEQ_IDLE: if (in_beat) seq_q <= SEQ_MUL;
        SEQ_MUL:  seq_q <= SEQ_CHK;
        SEQ_CHK:  seq_q <= div_start ? SEQ_DIV : SEQ_FIN;
        SEQ_DIV:  if (div_stat.done) seq_q <= SEQ_FIN;
        SEQ_FIN:  if (out_free) seq_q <= SEQ_IDLE;
        default:  seq_q <= SEQ_IDLE;
      endcase
    end
  end

  // tick capture and per-tick intermediates
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      now_q       <= now_ms_i;
      run_q       <= is_running_i;
      st_q        <= current_state_i;
      target_q    <= target_flow_i;
      pos_q       <= clamp_position_i;
      forced_q    <= forced_blockage_i;
      vol_q       <= volume_left_i;
      batt_q      <= battery_percent_i;
      edges_q     <= edge_count_i;
      interval_q  <= drop_interval_us_i;
      last_drop_q <= last_drop_ms_i;
      enough_q    <= enough_drops_i;
    end
    if (seq_q == SEQ_MUL) begin
      den_q       <= dfcc_pkg::DEN_W'(interval_q) * dfcc_pkg::DEN_W'(drops_per_ml_q);
      since_gt_q  <= CW'(since_t) > CW'(block_tmo_q);
      noise_due_q <= (now_t - last_noise_q) >= TW'(noise_win_q);
      noise_hit_q <= (edges_q - edge_snap_q) > 32'(noise_limit_q);
      corr_due_q  <= (now_t - last_corr_q) >= TW'(ctrl_period_q);
    end
    if (seq_q == SEQ_CHK) begin
      flow_go_q    <= window_ok && !den_small;
      flow_noisy_q <= window_ok && den_small;
    end
  end

  // persistent state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_corr_q    <= '0;
      last_noise_q   <= '0;
      edge_snap_q    <= '0;
      noisy_q        <= 1'b0;
      seen_q         <= 1'b0;
      clamp_closed_q <= 16'd600;
      flow_tol_q     <= 10'd50;
      ctrl_period_q  <= 16'd1000;
      corr_steps_q   <= 10'd5;
      block_tmo_q    <= 20'd30000;
      drops_per_ml_q <= 6'd20;
      noise_limit_q  <= 8'd25;
      noise_win_q    <= 16'd2000;
    end else begin
      if (fin_fire && upd_state) begin
        noisy_q <= noisy_n;
        seen_q  <= seen_n;
        if (noise_due_q) begin
          edge_snap_q  <= edges_q;
          last_noise_q <= now_t;
        end
        if (upd_corr) begin
          last_corr_q <= now_t;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          dfcc_pkg::CFG_CLAMP_CLOSED: clamp_closed_q <= cfg_data_i[15:0];
          dfcc_pkg::CFG_FLOW_TOL:     flow_tol_q     <= cfg_data_i[9:0];
          dfcc_pkg::CFG_CTRL_PERIOD:  ctrl_period_q  <= cfg_data_i[15:0];
          dfcc_pkg::CFG_CORR_STEPS:   corr_steps_q   <= cfg_data_i[9:0];
          dfcc_pkg::CFG_BLOCK_TMO:    block_tmo_q    <= cfg_data_i[19:0];
          dfcc_pkg::CFG_DROPS_PER_ML: drops_per_ml_q <= cfg_data_i[5:0];
          dfcc_pkg::CFG_NOISE_LIMIT:  noise_limit_q  <= cfg_data_i[7:0];
          dfcc_pkg::CFG_NOISE_WIN:    noise_win_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      o_state_q <= r_state;
      o_run_q   <= r_run;
      o_flow_q  <= r_flow;
      o_act_q   <= r_act;
      o_steps_q <= r_steps;
      o_noisy_q <= upd_state ? noisy_n : noisy_q;
      o_seen_q  <= upd_state ? seen_n : seen_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign next_state_o      = o_state_q;
  assign still_running_o   = o_run_q;
  assign flow_measured_o   = o_flow_q;
  assign motor_action_o    = o_act_q;
  assign motor_steps_o     = o_steps_q;
  assign noisy_flag_o      = o_noisy_q;
  assign drops_seen_flag_o = o_seen_q;

  // ---------------- assertions ----------------
  a_steps_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (motor_action_o == dfcc_pkg::MA_NONE ||
                    motor_action_o == dfcc_pkg::MA_DISABLE) |-> motor_steps_o == '0)
    else $error("motor steps nonzero without a move");

  a_flow_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> flow_measured_o <= 12'd3500)
    else $error("reported flow above limit");

  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |=> seen_q)
    else $error("drops-seen flag cleared");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> seq_q == SEQ_DIV)
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
